[rtl/kdrc_pkg.sv]
// types and constants shared by the known-device rssi capture block
`default_nettype none

package kdrc_pkg;

    // field widths fixed by the item format
    localparam int MAC_W   = 48;
    localparam int ID_W    = 16;
    localparam int RSSI_W  = 8;
    localparam int SLOT_W  = 5;
    localparam int COUNT_W = 6;
    localparam int CFG_W   = 8;

    // reset value of the rssi threshold
    localparam logic signed [RSSI_W-1:0] MIN_RSSI_RESET = -8'sd120;

    // action codes of an input beat
    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_CLEAR  = 2'd1,
        ACT_REPORT = 2'd2,
        ACT_DRAIN  = 2'd3
    } t_action;

    // configuration register indexes
    typedef enum logic {
        CFG_MIN_RSSI = 1'b0,
        CFG_ENTRIES  = 1'b1
    } t_cfg_idx;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic                     load;
        logic [SLOT_W-1:0]        slot;
        logic [MAC_W-1:0]         load_mac;
        logic [ID_W-1:0]          load_id;
        logic                     clear;
        logic                     look;
        logic [MAC_W-1:0]         key_mac;
        logic signed [RSSI_W-1:0] key_rssi;
        logic [COUNT_W-1:0]       limit;
        logic                     shift;
    } t_cell_ctrl;

    // per-cell status gathered by the sequencer
    typedef struct packed {
        logic                     win;
        logic                     is_new;
        logic                     emit;
        logic                     last;
        logic [ID_W-1:0]          id;
        logic signed [RSSI_W-1:0] rssi;
    } t_cell_stat;

endpackage

`default_nettype wire

[rtl/known_device_rssi_capture_top.sv]
// top level: command sequencer, configuration registers and the row of slot cells
//
//  channel   | signals                                      | transfer
//  ----------+----------------------------------------------+---------------------------
//  command   | start, busy, i_action .. i_rssi              | start && !busy at clk edge
//  result    | o_strobe, o_found .. o_last                  | beat when o_strobe, no stall
//  config    | i_cfg_we, i_cfg_idx, i_cfg_data              | i_cfg_we at clk edge
//
// load and clear finish at the accepting edge and give no result.
// report: lookup in the LOOK state, result strobed on the cycle after it; busy in LOOK.
// drain: the token walks the cell row one slot per cycle, one result beat for each
// seen slot; with nothing seen a single beat follows at once.
// active-low sync reset: seen flags, count, limit, control cleared; threshold preset.
`default_nettype none

module known_device_rssi_capture_top #(
    parameter int MAX_DEVICES = 32
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire  [1:0]                          i_action,
    input  wire  [kdrc_pkg::SLOT_W-1:0]         i_slot,
    input  wire  [kdrc_pkg::MAC_W-1:0]          i_mac,
    input  wire  [kdrc_pkg::ID_W-1:0]           i_device_id,
    input  wire  signed [kdrc_pkg::RSSI_W-1:0]  i_rssi,
    input  wire                                 i_cfg_we,
    input  wire                                 i_cfg_idx,
    input  wire  [kdrc_pkg::CFG_W-1:0]          i_cfg_data,
    output logic                                o_strobe,
    output logic                                o_found,
    output logic [kdrc_pkg::SLOT_W-1:0]         o_match_slot,
    output logic                                o_is_new,
    output logic [kdrc_pkg::COUNT_W-1:0]        o_seen_count,
    output logic [kdrc_pkg::ID_W-1:0]           o_out_id,
    output logic signed [kdrc_pkg::RSSI_W-1:0]  o_out_rssi,
    output logic                                o_item_valid,
    output logic                                o_last
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_LOOK  = 3'b010,
        ST_DRAIN = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic signed [kdrc_pkg::RSSI_W-1:0] r_min_rssi;
    logic [kdrc_pkg::COUNT_W-1:0]       r_entries;
    logic [kdrc_pkg::COUNT_W-1:0]       r_count;
    logic [kdrc_pkg::MAC_W-1:0]         r_key_mac;
    logic signed [kdrc_pkg::RSSI_W-1:0] r_key_rssi;
    logic                               r_pass;

    logic                                r_strobe;
    logic                                r_found;
    logic [kdrc_pkg::SLOT_W-1:0]         r_match_slot;
    logic                                r_is_new;
    logic [kdrc_pkg::COUNT_W-1:0]        r_seen_count;
    logic [kdrc_pkg::ID_W-1:0]           r_out_id;
    logic signed [kdrc_pkg::RSSI_W-1:0]  r_out_rssi;
    logic                                r_item_valid;
    logic                                r_last;

    logic                 w_accept;
    kdrc_pkg::t_action    w_action;
    logic                 w_drain_go;
    logic                 w_drain_empty;
    kdrc_pkg::t_cell_ctrl w_ctrl;

    logic [MAX_DEVICES:0] w_hit;
    logic [MAX_DEVICES:0] w_seen;
    logic [MAX_DEVICES:0] w_tok;
    kdrc_pkg::t_cell_stat w_stat [MAX_DEVICES];

    // gathered cell status
    logic                               w_win_any;
    logic                               w_new_any;
    logic [kdrc_pkg::SLOT_W-1:0]        w_win_slot;
    logic                               w_emit_any;
    logic                               w_last_any;
    logic [kdrc_pkg::ID_W-1:0]          w_emit_id;
    logic [kdrc_pkg::RSSI_W-1:0]        w_emit_rssi;
    logic [kdrc_pkg::COUNT_W-1:0]       w_count_next;

    assign w_accept      = start && !busy;
    assign w_action      = kdrc_pkg::t_action'(i_action);
    assign w_drain_go    = w_accept && (w_action == kdrc_pkg::ACT_DRAIN) && w_seen[0];
    assign w_drain_empty = w_accept && (w_action == kdrc_pkg::ACT_DRAIN) && !w_seen[0];
    assign busy          = (r_state != ST_IDLE);

    // broadcast to the cells
    always_comb begin
        w_ctrl          = '0;
        w_ctrl.load     = w_accept && (w_action == kdrc_pkg::ACT_LOAD);
        w_ctrl.slot     = i_slot;
        w_ctrl.load_mac = i_mac;
        w_ctrl.load_id  = i_device_id;
        w_ctrl.clear    = w_accept && (w_action == kdrc_pkg::ACT_CLEAR);
        w_ctrl.look     = (r_state == ST_LOOK) && r_pass;
        w_ctrl.key_mac  = r_key_mac;
        w_ctrl.key_rssi = r_key_rssi;
        w_ctrl.limit    = r_entries;
        w_ctrl.shift    = w_drain_go || (r_state == ST_DRAIN);
    end

    assign w_hit[0]           = 1'b0;
    assign w_seen[MAX_DEVICES] = 1'b0;
    assign w_tok[0]           = w_drain_go;

    // row of slot cells
    for (genvar g = 0; g < MAX_DEVICES; g++) begin : g_cell
        kdrc_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_hit        (w_hit[g]),
            .o_hit        (w_hit[g+1]),
            .i_later_seen (w_seen[g+1]),
            .o_seen_chain (w_seen[g]),
            .i_tok        (w_tok[g]),
            .o_tok        (w_tok[g+1]),
            .o_stat       (w_stat[g])
        );
    end

    // or-reduce the one-hot cell outputs
    always_comb begin
        w_win_any   = 1'b0;
        w_new_any   = 1'b0;
        w_win_slot  = '0;
        w_emit_any  = 1'b0;
        w_last_any  = 1'b0;
        w_emit_id   = '0;
        w_emit_rssi = '0;
        for (int k = 0; k < MAX_DEVICES; k++) begin
            w_win_any   = w_win_any | w_stat[k].win;
            w_new_any   = w_new_any | w_stat[k].is_new;
            w_win_slot  = w_win_slot | (w_stat[k].win ? kdrc_pkg::SLOT_W'(k) : '0);
            w_emit_any  = w_emit_any | w_stat[k].emit;
            w_last_any  = w_last_any | w_stat[k].last;
            w_emit_id   = w_emit_id | w_stat[k].id;
            w_emit_rssi = w_emit_rssi | w_stat[k].rssi;
        end
    end

    assign w_count_next = r_count + kdrc_pkg::COUNT_W'(w_new_any);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && (w_action == kdrc_pkg::ACT_REPORT)) begin
                    n_state = ST_LOOK;
                end else if (w_drain_go) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_LOOK: begin
                n_state = ST_IDLE;
            end
            ST_DRAIN: begin
                if (w_tok[MAX_DEVICES]) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_min_rssi <= kdrc_pkg::MIN_RSSI_RESET;
            r_entries  <= '0;
            r_count    <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (kdrc_pkg::t_cfg_idx'(i_cfg_idx))
                    kdrc_pkg::CFG_MIN_RSSI: r_min_rssi <= i_cfg_data;
                    kdrc_pkg::CFG_ENTRIES:  r_entries  <= i_cfg_data[kdrc_pkg::COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (w_ctrl.clear) begin
                r_count <= '0;
            end else if (r_state == ST_LOOK) begin
                r_count <= w_count_next;
            end
            r_strobe <= (r_state == ST_LOOK) || w_emit_any || w_drain_empty;
        end
    end

    // report key capture
    always_ff @(posedge i_clk) begin
        if (w_accept && (w_action == kdrc_pkg::ACT_REPORT)) begin
            r_key_mac  <= i_mac;
            r_key_rssi <= i_rssi;
            r_pass     <= (i_rssi >= r_min_rssi);
        end
    end

    // result beat register
    always_ff @(posedge i_clk) begin
        if (r_state == ST_LOOK) begin
            r_found      <= w_win_any;
            r_match_slot <= w_win_slot;
            r_is_new     <= w_new_any;
            r_seen_count <= w_count_next;
            r_out_id     <= '0;
            r_out_rssi   <= '0;
            r_item_valid <= 1'b0;
            r_last       <= 1'b1;
        end else if (w_emit_any) begin
            r_found      <= 1'b0;
            r_match_slot <= '0;
            r_is_new     <= 1'b0;
            r_seen_count <= r_count;
            r_out_id     <= w_emit_id;
            r_out_rssi   <= w_emit_rssi;
            r_item_valid <= 1'b1;
            r_last       <= w_last_any;
        end else if (w_drain_empty) begin
            r_found      <= 1'b0;
            r_match_slot <= '0;
            r_is_new     <= 1'b0;
            r_seen_count <= r_count;
            r_out_id     <= '0;
            r_out_rssi   <= '0;
            r_item_valid <= 1'b0;
            r_last       <= 1'b1;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_found      = r_found;
    assign o_match_slot = r_match_slot;
    assign o_is_new     = r_is_new;
    assign o_seen_count = r_seen_count;
    assign o_out_id     = r_out_id;
    assign o_out_rssi   = r_out_rssi;
    assign o_item_valid = r_item_valid;
    assign o_last       = r_last;

endmodule

`default_nettype wire

[rtl/kdrc_cell.sv]
// one table slot: stored address, id, rssi and seen flag with chain links
`default_nettype none

module kdrc_cell #(
    parameter int CELL_IDX = 0
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  kdrc_pkg::t_cell_ctrl  i_ctrl,
    input  wire                   i_hit,
    output logic                  o_hit,
    input  wire                   i_later_seen,
    output logic                  o_seen_chain,
    input  wire                   i_tok,
    output logic                  o_tok,
    output kdrc_pkg::t_cell_stat  o_stat
);

    localparam logic [6:0] IDX = 7'(CELL_IDX);

    logic [kdrc_pkg::MAC_W-1:0]         r_mac;
    logic [kdrc_pkg::ID_W-1:0]          r_id;
    logic signed [kdrc_pkg::RSSI_W-1:0] r_rssi;
    logic                               r_seen;
    logic                               r_tok;

    logic w_sel;
    logic w_match;
    logic w_win;
    logic w_emit;

    // slot decode and search window
    assign w_sel   = i_ctrl.load && ({2'b00, i_ctrl.slot} == IDX);
    assign w_match = (r_mac == i_ctrl.key_mac) && (IDX < {1'b0, i_ctrl.limit});
    assign w_win   = i_ctrl.look && w_match && !i_hit;
    assign w_emit  = r_tok && r_seen;

    // priority link: a lower slot that matched blocks this one
    assign o_hit        = i_hit || w_match;
    assign o_seen_chain = r_seen || i_later_seen;
    assign o_tok        = r_tok;

    assign o_stat.win    = w_win;
    assign o_stat.is_new = w_win && !r_seen;
    assign o_stat.emit   = w_emit;
    assign o_stat.last   = w_emit && !i_later_seen;
    assign o_stat.id     = w_emit ? r_id : '0;
    assign o_stat.rssi   = w_emit ? r_rssi : '0;

    // table contents
    always_ff @(posedge i_clk) begin
        if (w_sel) begin
            r_mac <= i_ctrl.load_mac;
            r_id  <= i_ctrl.load_id;
        end
        if (w_win) begin
            r_rssi <= i_ctrl.key_rssi;
        end
    end

    // seen flag and drain token
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
            r_tok  <= 1'b0;
        end else begin
            if (i_ctrl.clear) begin
                r_seen <= 1'b0;
            end else if (w_win) begin
                r_seen <= 1'b1;
            end
            r_tok <= i_ctrl.shift ? i_tok : 1'b0;
        end
    end

endmodule

`default_nettype wire

[dv/kdrc_sighting_checker.sv]
// checker for the known-device rssi capture block: mirrors the table and compares result beats
`timescale 1ns / 1ps

module kdrc_sighting_checker
    import kdrc_pkg::*;
#(
    parameter int MAX_DEVICES = 32
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    input  wire                       i_busy,
    input  wire  [1:0]                i_action,
    input  wire  [SLOT_W-1:0]         i_slot,
    input  wire  [MAC_W-1:0]          i_mac,
    input  wire  [ID_W-1:0]           i_device_id,
    input  wire  signed [RSSI_W-1:0]  i_rssi,
    input  wire                       i_cfg_we,
    input  wire                       i_cfg_idx,
    input  wire  [CFG_W-1:0]          i_cfg_data,
    input  wire                       i_strobe,
    input  wire                       i_found,
    input  wire  [SLOT_W-1:0]         i_match_slot,
    input  wire                       i_is_new,
    input  wire  [COUNT_W-1:0]        i_seen_count,
    input  wire  [ID_W-1:0]           i_out_id,
    input  wire  signed [RSSI_W-1:0]  i_out_rssi,
    input  wire                       i_item_valid,
    input  wire                       i_last,
    output int                        o_fail_count,
    output int                        o_pending
);

    // one result beat as the block presents it
    typedef struct packed {
        logic                     found;
        logic [SLOT_W-1:0]        match_slot;
        logic                     is_new;
        logic [COUNT_W-1:0]       seen_count;
        logic [ID_W-1:0]          out_id;
        logic signed [RSSI_W-1:0] out_rssi;
        logic                     item_valid;
        logic                     last;
    } t_sighting_beat;

    // mirrored table, flags and registers
    logic [MAC_W-1:0]         mac_copy   [MAX_DEVICES];
    logic [ID_W-1:0]          id_copy    [MAX_DEVICES];
    logic signed [RSSI_W-1:0] rssi_copy  [MAX_DEVICES];
    logic                     seen_copy  [MAX_DEVICES];
    logic [COUNT_W-1:0]       distinct_copy;
    logic signed [RSSI_W-1:0] threshold_copy;
    logic [COUNT_W-1:0]       searched_copy;

    t_sighting_beat expected_beats[$];
    int             mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic clear_mirror();
        for (int i = 0; i < MAX_DEVICES; i++) begin
            mac_copy[i]  = '0;
            id_copy[i]   = '0;
            rssi_copy[i] = '0;
            seen_copy[i] = 1'b0;
        end
        distinct_copy  = '0;
        threshold_copy = MIN_RSSI_RESET;
        searched_copy  = '0;
        expected_beats.delete();
    endtask

    // work out the beats one accepted command causes and queue them
    task automatic predict_sightings(input t_action act, input logic [SLOT_W-1:0] slot,
                                     input logic [MAC_W-1:0] mac, input logic [ID_W-1:0] dev_id,
                                     input logic signed [RSSI_W-1:0] rssi);
        t_sighting_beat beat;
        int             limit;
        bit             hit;
        int             emitted;
        beat = '0;
        hit = 1'b0;
        emitted = 0;
        case (act)
            ACT_LOAD: begin
                if (slot < MAX_DEVICES) begin
                    mac_copy[slot] = mac;
                    id_copy[slot]  = dev_id;
                end
            end
            ACT_CLEAR: begin
                for (int i = 0; i < MAX_DEVICES; i++) seen_copy[i] = 1'b0;
                distinct_copy = '0;
            end
            ACT_REPORT: begin
                if (rssi >= threshold_copy) begin
                    limit = (searched_copy > MAX_DEVICES) ? MAX_DEVICES : int'(searched_copy);
                    // lowest matching slot wins
                    for (int i = 0; i < limit; i++) begin
                        if (!hit && mac_copy[i] == mac) begin
                            hit = 1'b1;
                            beat.found      = 1'b1;
                            beat.match_slot = SLOT_W'(i);
                            if (!seen_copy[i]) begin
                                seen_copy[i]  = 1'b1;
                                distinct_copy = distinct_copy + 1'b1;
                                beat.is_new   = 1'b1;
                            end
                            rssi_copy[i] = rssi;
                        end
                    end
                end
                beat.seen_count = distinct_copy;
                beat.last       = 1'b1;
                expected_beats.push_back(beat);
            end
            default: begin
                // drain lists seen slots in order, the final one marked
                for (int i = 0; i < MAX_DEVICES; i++) begin
                    if (seen_copy[i]) begin
                        beat = '0;
                        beat.seen_count = distinct_copy;
                        beat.out_id     = id_copy[i];
                        beat.out_rssi   = rssi_copy[i];
                        beat.item_valid = 1'b1;
                        expected_beats.push_back(beat);
                        emitted++;
                    end
                end
                if (emitted == 0) begin
                    beat = '0;
                    beat.seen_count = distinct_copy;
                    beat.last       = 1'b1;
                    expected_beats.push_back(beat);
                end else begin
                    expected_beats[expected_beats.size()-1].last = 1'b1;
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // compare one result beat against the oldest expectation
    task automatic compare_beat();
        t_sighting_beat want;
        if (expected_beats.size() == 0) begin
            $error("result beat with no expectation pending");
            mismatches++;
        end else begin
            want = expected_beats.pop_front();
            check_field("found", want.found, i_found);
            check_field("match_slot", want.match_slot, i_match_slot);
            check_field("is_new", want.is_new, i_is_new);
            check_field("seen_count", want.seen_count, i_seen_count);
            check_field("out_id", want.out_id, i_out_id);
            check_field("out_rssi", want.out_rssi, i_out_rssi);
            check_field("item_valid", want.item_valid, i_item_valid);
            check_field("last", want.last, i_last);
        end
    endtask

    // sample every channel at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_mirror();
        end else begin
            if (i_strobe) compare_beat();
            if (i_cfg_we) begin
                if (t_cfg_idx'(i_cfg_idx) == CFG_MIN_RSSI) threshold_copy = i_cfg_data[RSSI_W-1:0];
                else searched_copy = i_cfg_data[COUNT_W-1:0];
            end
            if (i_start && !i_busy)
                predict_sightings(t_action'(i_action), i_slot, i_mac, i_device_id, i_rssi);
        end
        o_pending = expected_beats.size();
    end

endmodule

[dv/tb_known_device_rssi_capture_top.sv]
// testbench top: clock, reset, command and configuration stimulus, and the verdict
`timescale 1ns / 1ps

module tb_known_device_rssi_capture_top;
    import kdrc_pkg::*;

    localparam int MAX_DEVICES = 32;
    localparam int DRAIN_SETTLE = MAX_DEVICES + 8;
    localparam int RANDOM_ITEMS = 52;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [1:0]               i_action = ACT_LOAD;
    logic [SLOT_W-1:0]        i_slot = '0;
    logic [MAC_W-1:0]         i_mac = '0;
    logic [ID_W-1:0]          i_device_id = '0;
    logic signed [RSSI_W-1:0] i_rssi = '0;
    logic                     i_cfg_we = 1'b0;
    logic                     i_cfg_idx = CFG_MIN_RSSI;
    logic [CFG_W-1:0]         i_cfg_data = '0;
    logic                     o_strobe;
    logic                     o_found;
    logic [SLOT_W-1:0]        o_match_slot;
    logic                     o_is_new;
    logic [COUNT_W-1:0]       o_seen_count;
    logic [ID_W-1:0]          o_out_id;
    logic signed [RSSI_W-1:0] o_out_rssi;
    logic                     o_item_valid;
    logic                     o_last;
    int                       fail_count;
    int                       pending;

    // stimulus-side view of which slots hold an address
    logic [MAC_W-1:0] table_macs [MAX_DEVICES];
    bit               slot_loaded[MAX_DEVICES];
    int               loaded_prefix = 0;
    int               random_sent = 0;

    always #4 i_clk = ~i_clk;

    known_device_rssi_capture_top #(.MAX_DEVICES(MAX_DEVICES)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(i_action), .i_slot(i_slot), .i_mac(i_mac), .i_device_id(i_device_id),
        .i_rssi(i_rssi), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_strobe(o_strobe), .o_found(o_found), .o_match_slot(o_match_slot),
        .o_is_new(o_is_new), .o_seen_count(o_seen_count), .o_out_id(o_out_id),
        .o_out_rssi(o_out_rssi), .o_item_valid(o_item_valid), .o_last(o_last)
    );

    kdrc_sighting_checker #(.MAX_DEVICES(MAX_DEVICES)) u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_action(i_action), .i_slot(i_slot), .i_mac(i_mac), .i_device_id(i_device_id),
        .i_rssi(i_rssi), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_strobe(o_strobe), .i_found(o_found), .i_match_slot(o_match_slot),
        .i_is_new(o_is_new), .i_seen_count(o_seen_count), .i_out_id(o_out_id),
        .i_out_rssi(o_out_rssi), .i_item_valid(o_item_valid), .i_last(o_last),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic logic [MAC_W-1:0] random_mac();
        logic [MAC_W-1:0] m;
        m[47:32] = 16'($urandom);
        m[31:0]  = $urandom;
        return m;
    endfunction

    // present one command beat and hold it until the block takes it
    task automatic send_command(input t_action act, input logic [SLOT_W-1:0] slot,
                                input logic [MAC_W-1:0] mac, input logic [ID_W-1:0] dev_id,
                                input logic signed [RSSI_W-1:0] rssi);
        start       <= 1'b1;
        i_action    <= act;
        i_slot      <= slot;
        i_mac       <= mac;
        i_device_id <= dev_id;
        i_rssi      <= rssi;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (act == ACT_LOAD) begin
            table_macs[slot]  = mac;
            slot_loaded[slot] = 1'b1;
            while (loaded_prefix < MAX_DEVICES && slot_loaded[loaded_prefix]) loaded_prefix++;
        end
    endtask

    // random sender gap with start dropped, taken one time in four when allowed
    task automatic maybe_pause(input bit allowed);
        if (allowed && $urandom_range(3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(17, 1)) @(posedge i_clk);
        end
    endtask

    // hold off until every expected beat is in and the block has gone quiet
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || busy) @(posedge i_clk);
        repeat (DRAIN_SETTLE) @(posedge i_clk);
    endtask

    // both registers, back to back with the enable held high
    task automatic write_config(input logic signed [RSSI_W-1:0] threshold,
                                input logic [CFG_W-1:0] searched);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_MIN_RSSI;
        i_cfg_data <= threshold;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_ENTRIES;
        i_cfg_data <= searched;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // one random command with mostly known addresses
    task automatic send_random_command(input bit gaps);
        int                       pick;
        logic [MAC_W-1:0]         mac;
        logic signed [RSSI_W-1:0] rssi;
        pick = $urandom_range(99);
        mac  = random_mac();
        rssi = RSSI_W'($urandom);
        if (pick < 15) begin
            if ($urandom_range(4) == 0) mac = table_macs[$urandom_range(MAX_DEVICES-1)];
            send_command(ACT_LOAD, SLOT_W'($urandom), mac, ID_W'($urandom), rssi);
        end else if (pick < 22) begin
            send_command(ACT_CLEAR, SLOT_W'($urandom), mac, ID_W'($urandom), rssi);
        end else if (pick < 34) begin
            send_command(ACT_DRAIN, SLOT_W'($urandom), mac, ID_W'($urandom), rssi);
        end else begin
            if ($urandom_range(4) != 0) mac = table_macs[$urandom_range(MAX_DEVICES-1)];
            if ($urandom_range(9) == 0) rssi = $urandom_range(1) ? 8'sd127 : -8'sd128;
            send_command(ACT_REPORT, SLOT_W'($urandom), mac, ID_W'($urandom), rssi);
        end
        random_sent++;
        maybe_pause(gaps);
    endtask

    initial begin
        logic signed [RSSI_W-1:0] threshold;
        logic [CFG_W-1:0]         searched;
        logic [MAC_W-1:0]         twin_mac;
        bit                       quiet;
        int                       phase_len;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, reset threshold: ignored and unmatched reports, empty drain
        twin_mac = random_mac();
        send_command(ACT_REPORT, 5'd0, '0, 16'h0000, -8'sd128);
        send_command(ACT_REPORT, 5'd31, '1, 16'hFFFF, 8'sd127);
        send_command(ACT_DRAIN, 5'd0, '0, 16'h0000, 8'sd0);
        send_command(ACT_LOAD, 5'd0, '0, 16'h0000, 8'sd0);
        send_command(ACT_LOAD, 5'd1, '1, 16'hFFFF, -8'sd1);
        send_command(ACT_LOAD, 5'd2, twin_mac, ID_W'($urandom), 8'sd0);
        send_command(ACT_LOAD, 5'd3, twin_mac, ID_W'($urandom), 8'sd0);
        send_command(ACT_LOAD, 5'd31, random_mac(), ID_W'($urandom), 8'sd0);
        wait_drained();
        write_config(-8'sd128, 8'd4);

        // duplicate address, zero rssi, out-of-range slot, reload of a seen slot
        send_command(ACT_REPORT, 5'd0, twin_mac, 16'h0000, 8'sd0);
        send_command(ACT_REPORT, 5'd0, table_macs[31], 16'h0000, 8'sd5);
        send_command(ACT_REPORT, 5'd0, '0, 16'h0000, -8'sd128);
        send_command(ACT_REPORT, 5'd0, '1, 16'h0000, 8'sd127);
        send_command(ACT_REPORT, 5'd0, '0, 16'h0000, -8'sd1);
        send_command(ACT_LOAD, 5'd0, '0, 16'h1234, 8'sd0);
        send_command(ACT_DRAIN, 5'd0, '0, 16'h0000, 8'sd0);
        send_command(ACT_CLEAR, 5'd0, '0, 16'h0000, 8'sd0);
        send_command(ACT_DRAIN, 5'd0, '0, 16'h0000, 8'sd0);
        wait_drained();
        write_config(8'sd127, 8'd4);

        // strongest threshold: just below is ignored, equal passes
        send_command(ACT_REPORT, 5'd0, '1, 16'h0000, 8'sd126);
        send_command(ACT_REPORT, 5'd0, '1, 16'h0000, 8'sd127);
        send_command(ACT_DRAIN, 5'd0, '0, 16'h0000, 8'sd0);

        // fill the rest of the table, a few slots sharing an address
        for (int s = 4; s < MAX_DEVICES; s++) begin
            twin_mac = ($urandom_range(5) == 0) ? table_macs[$urandom_range(s-1)] : random_mac();
            send_command(ACT_LOAD, s[SLOT_W-1:0], twin_mac, ID_W'($urandom), RSSI_W'($urandom));
            maybe_pause(1'b1);
        end

        // random phases, each under a fresh configuration
        while (random_sent < RANDOM_ITEMS) begin
            wait_drained();
            case ($urandom_range(9))
                0, 1, 2: threshold = -8'sd128;
                3:       threshold = 8'sd127;
                4:       threshold = 8'sd0;
                default: threshold = RSSI_W'($urandom_range(108) - 128);
            endcase
            case ($urandom_range(5))
                0:       searched = 8'(MAX_DEVICES);
                1:       searched = 8'(MAX_DEVICES + 1 + $urandom_range(30));
                2:       searched = 8'd0;
                default: searched = CFG_W'($urandom_range(loaded_prefix));
            endcase
            // spare upper bits of the count register
            searched[CFG_W-1:COUNT_W] = (CFG_W-COUNT_W)'($urandom);
            write_config(threshold, searched);
            quiet     = ($urandom_range(3) == 0) || (random_sent >= RANDOM_ITEMS * 4 / 5);
            phase_len = 6 + $urandom_range(10);
            for (int n = 0; n < phase_len && random_sent < RANDOM_ITEMS; n++)
                send_random_command(!quiet);
        end

        wait_drained();
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
rtl/kdrc_pkg.sv
rtl/kdrc_cell.sv
rtl/known_device_rssi_capture_top.sv
dv/kdrc_sighting_checker.sv
dv/tb_known_device_rssi_capture_top.sv
